>>> hdl/btcp_pkg.sv
// ----------------------------------------------------------------------------
// btcp_pkg
// Word types, register indexes and fixed-point helpers for the box/triangle
// collision push-out block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package btcp_pkg;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] bx;
        logic signed [31:0] by_coord;
        logic signed [31:0] bz;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
    } t_in_word;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               on_ground;
    } t_out_word;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_Z = 2'd2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TRI  = 1'b1;

    // shared multiplier operand widths
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 35;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic signed [33:0] HALF_Q16      = 34'sd32768;
    localparam logic signed [33:0] ONE_Q16       = 34'sd65536;
    localparam logic signed [33:0] BOX_BELOW_Q16 = 34'sd1310720;
    localparam logic signed [34:0] CENTRE_DROP   = 35'sd622592;
    localparam logic signed [31:0] GROUND_NY_Q30 = 32'sd697932186;

    // divide by 2^16 rounding toward zero
    function automatic logic signed [17:0] trunc_q16(input logic signed [33:0] v);
        logic signed [33:0] t;
        t = (v < 0) ? v + 34'sd65535 : v;
        return t[33:16];
    endfunction

    // divide by 2^30 rounding toward zero
    function automatic logic signed [37:0] trunc_q30(input logic signed [MUL_P_W-1:0] p);
        logic signed [MUL_P_W-1:0] t;
        t = (p < 0) ? p + 68'sd1073741823 : p;
        return t[MUL_P_W-1:30];
    endfunction

endpackage

>>> hdl/box_triangle_collision_pushout.sv
// ----------------------------------------------------------------------------
// box_triangle_collision_pushout
// A load word goes straight to the final step; a coarse miss ends after the
// box test; a full triangle test runs on through the normalize shifts, the
// serial square root and the three serial divides. One word at a time.
// Reset (synchronous, active low) clears position, ground flag, last-position
// registers and the sequencer; there is no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module box_triangle_collision_pushout (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  btcp_pkg::t_in_word                  i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output btcp_pkg::t_out_word                 o_out_word,
    input  logic                                i_cfg_we,
    input  logic [btcp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [31:0]                         i_cfg_data
);
    import btcp_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_COARSE = 4'd1;
    localparam logic [3:0] S_EDGE   = 4'd2;
    localparam logic [3:0] S_CROSS  = 4'd3;
    localparam logic [3:0] S_MAG    = 4'd4;
    localparam logic [3:0] S_NORM   = 4'd5;
    localparam logic [3:0] S_SQ     = 4'd6;
    localparam logic [3:0] S_SQRT   = 4'd7;
    localparam logic [3:0] S_DIV    = 4'd8;
    localparam logic [3:0] S_DOT    = 4'd9;
    localparam logic [3:0] S_RAD    = 4'd10;
    localparam logic [3:0] S_PUSH   = 4'd11;
    localparam logic [3:0] S_DIST   = 4'd12;
    localparam logic [3:0] S_DONE   = 4'd13;

    logic [3:0]          r_state;
    logic [2:0]          r_cnt;
    logic                r_kick;
    logic                r_is_load;
    logic                r_cand;
    logic signed [31:0]  r_pos  [3];
    logic                r_ground;
    logic signed [31:0]  r_last [3];
    logic signed [31:0]  r_a    [3];
    logic signed [31:0]  r_b    [3];
    logic signed [31:0]  r_c    [3];
    logic signed [31:0]  r_u    [3];
    logic signed [31:0]  r_v    [3];
    logic signed [64:0]  r_acc;
    logic signed [64:0]  r_cr   [3];
    logic [63:0]         r_mag  [3];
    logic                r_neg  [3];
    logic [63:0]         r_m;
    logic [63:0]         r_sum;
    logic [31:0]         r_len;
    logic signed [31:0]  r_n    [3];
    logic signed [37:0]  r_s;
    logic signed [22:0]  r_push;
    logic signed [31:0]  r_newp [3];
    logic signed [32:0]  r_d    [3];
    logic signed [59:0]  r_diff;
    logic                r_out_valid;
    t_out_word           r_out;

    // shared units
    logic signed [MUL_A_W-1:0] c_ma;
    logic signed [MUL_B_W-1:0] c_mb;
    logic signed [MUL_P_W-1:0] w_prod;
    logic                      w_sq_done;
    logic [31:0]               w_root;
    logic                      w_div_done;
    logic [30:0]               w_quo;

    btcp_mul u_mul (
        .i_clk (i_clk),
        .i_a   (c_ma),
        .i_b   (c_mb),
        .o_p   (w_prod)
    );

    btcp_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_kick && (r_state == S_SQRT)),
        .i_x     (r_sum),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    logic [1:0] c_ix;
    logic [1:0] c_kx;

    assign c_ix = (r_cnt < 3'd3) ? r_cnt[1:0] : 2'd0;
    assign c_kx = (r_cnt != 3'd0) ? 2'(r_cnt - 3'd1) : 2'd0;

    btcp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_kick && (r_state == S_DIV)),
        .i_num   (r_mag[c_ix][30:0]),
        .i_den   (r_len),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // coarse box test
    logic signed [31:0] c_mn, c_mx;
    logic signed [17:0] c_lo, c_hi, c_pmin, c_pmax;
    logic signed [33:0] c_sp, c_off_lo, c_off_hi;
    logic               c_ovl;

    always_comb begin
        c_ovl = 1'b1;
        c_mn = '0; c_mx = '0; c_lo = '0; c_hi = '0;
        c_pmin = '0; c_pmax = '0; c_sp = '0; c_off_lo = '0; c_off_hi = '0;
        for (int i = 0; i < 3; i++) begin
            c_mn = r_a[i];
            c_mx = r_a[i];
            if (r_b[i] < c_mn) c_mn = r_b[i];
            if (r_b[i] > c_mx) c_mx = r_b[i];
            if (r_c[i] < c_mn) c_mn = r_c[i];
            if (r_c[i] > c_mx) c_mx = r_c[i];
            c_lo = trunc_q16(34'(c_mn));
            c_hi = trunc_q16(34'(c_mx));
            c_off_lo = (i == 1) ? BOX_BELOW_Q16 : HALF_Q16;
            c_off_hi = (i == 1) ? ONE_Q16 : HALF_Q16;
            c_sp = 34'(r_pos[i]);
            c_pmin = trunc_q16(c_sp - c_off_lo);
            c_pmax = trunc_q16(c_sp + c_off_hi);
            if (c_pmax < c_lo || c_pmin > c_hi) c_ovl = 1'b0;
        end
    end

    // edge vectors, halved together when any one's magnitude reaches 2^31
    logic signed [32:0] c_ue [3];
    logic signed [32:0] c_ve [3];
    logic signed [32:0] c_t1 [3];
    logic signed [32:0] c_t2 [3];
    logic               c_big;

    always_comb begin
        c_big = 1'b0;
        for (int i = 0; i < 3; i++) begin
            c_ue[i] = 33'(r_b[i]) - 33'(r_a[i]);
            c_ve[i] = 33'(r_c[i]) - 33'(r_b[i]);
            if (c_ue[i] >= 33'sh0_8000_0000 || c_ue[i] <= 33'sh1_8000_0000) c_big = 1'b1;
            if (c_ve[i] >= 33'sh0_8000_0000 || c_ve[i] <= 33'sh1_8000_0000) c_big = 1'b1;
            // bias negatives so the shift rounds toward zero
            c_t1[i] = (c_ue[i] < 0) ? c_ue[i] + 33'sd1 : c_ue[i];
            c_t2[i] = (c_ve[i] < 0) ? c_ve[i] + 33'sd1 : c_ve[i];
        end
    end

    // cross product magnitudes
    logic [63:0] c_mag [3];
    logic [63:0] c_mmax;

    always_comb begin
        c_mmax = '0;
        for (int i = 0; i < 3; i++) begin
            c_mag[i] = r_cr[i][64] ? 64'(-r_cr[i]) : r_cr[i][63:0];
            if (c_mag[i] > c_mmax) c_mmax = c_mag[i];
        end
    end

    // multiplier operands
    always_comb begin
        c_ma = '0;
        c_mb = '0;
        case (r_state)
            S_CROSS: begin
                case (r_cnt)
                    3'd0: begin c_ma = 33'(r_u[1]); c_mb = 35'(r_v[2]); end
                    3'd1: begin c_ma = 33'(r_u[2]); c_mb = 35'(r_v[1]); end
                    3'd2: begin c_ma = 33'(r_u[2]); c_mb = 35'(r_v[0]); end
                    3'd3: begin c_ma = 33'(r_u[0]); c_mb = 35'(r_v[2]); end
                    3'd4: begin c_ma = 33'(r_u[0]); c_mb = 35'(r_v[1]); end
                    3'd5: begin c_ma = 33'(r_u[1]); c_mb = 35'(r_v[0]); end
                    default: begin c_ma = '0; c_mb = '0; end
                endcase
            end
            S_SQ: begin
                c_ma = {2'b00, r_mag[c_ix][30:0]};
                c_mb = {4'b0000, r_mag[c_ix][30:0]};
            end
            S_DOT: begin
                c_ma = 33'(r_n[c_ix]);
                c_mb = 35'(r_pos[c_ix]) - 35'(r_a[c_ix])
                       - ((c_ix == 2'd1) ? CENTRE_DROP : 35'sd0);
            end
            S_PUSH: begin
                c_ma = 33'(r_n[c_ix]);
                c_mb = 35'(r_push);
            end
            S_DIST: begin
                c_ma = r_d[c_ix];
                c_mb = 35'(r_d[c_ix])
                       + ((35'(r_pos[c_ix]) - 35'(r_last[c_ix])) <<< 1);
            end
            default: begin
                c_ma = '0;
                c_mb = '0;
            end
        endcase
    end

    // push step: new coordinate with saturation
    logic signed [37:0] c_delta;
    logic signed [38:0] c_np;
    logic signed [31:0] c_sat;
    logic signed [32:0] c_dd;

    always_comb begin
        c_delta = trunc_q30(w_prod);
        c_np    = 39'(r_pos[c_kx]) + 39'(c_delta);
        if (c_np > 39'sd2147483647) begin
            c_sat = 32'sh7fff_ffff;
        end else if (c_np < -39'sd2147483648) begin
            c_sat = 32'sh8000_0000;
        end else begin
            c_sat = c_np[31:0];
        end
        c_dd = 33'(c_sat) - 33'(r_pos[c_kx]);
    end

    // box projection radius on the normal
    logic [30:0]        c_abs [3];
    logic [50:0]        c_racc;
    logic [20:0]        c_r;
    logic [37:0]        c_sabs;
    logic signed [37:0] c_pushw;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_abs[i] = r_n[i][31] ? 31'(-r_n[i]) : r_n[i][30:0];
        end
        c_racc  = 51'(c_abs[0]) * 51'd32768 + 51'(c_abs[1]) * 51'd688128
                  + 51'(c_abs[2]) * 51'd32768;
        c_r     = c_racc[50:30];
        c_sabs  = r_s[37] ? 38'(-r_s) : r_s;
        c_pushw = 38'($signed({17'b0, c_r})) - r_s;
    end

    // final update
    logic               c_commit;
    logic signed [31:0] c_fpos [3];
    logic               c_fground;
    logic               c_owrite;

    always_comb begin
        c_commit  = !r_is_load && r_cand && !(r_diff > 0);
        c_fground = r_ground;
        for (int i = 0; i < 3; i++) c_fpos[i] = r_pos[i];
        if (r_is_load) begin
            for (int i = 0; i < 3; i++) c_fpos[i] = r_a[i];
            c_fground = 1'b0;
        end else if (c_commit) begin
            for (int i = 0; i < 3; i++) c_fpos[i] = r_newp[i];
            if (r_n[1] > GROUND_NY_Q30) c_fground = 1'b1;
        end
    end

    assign c_owrite = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // odd steps of the cross product finish a component
    function automatic logic c_kx_odd(input logic [2:0] cnt);
        logic [2:0] k;
        k = cnt - 3'd1;
        return k[0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_kick      <= 1'b0;
            r_out_valid <= 1'b0;
            r_ground    <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_pos[i]  <= '0;
                r_last[i] <= '0;
            end
        end else begin
            r_kick <= 1'b0;
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LAST_X: r_last[0] <= i_cfg_data;
                    CFG_LAST_Y: r_last[1] <= i_cfg_data;
                    CFG_LAST_Z: r_last[2] <= i_cfg_data;
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_is_load <= (i_in_word.cmd == CMD_LOAD);
                        r_cand    <= 1'b1;
                        r_a[0] <= i_in_word.ax;
                        r_a[1] <= i_in_word.ay;
                        r_a[2] <= i_in_word.az;
                        r_b[0] <= i_in_word.bx;
                        r_b[1] <= i_in_word.by_coord;
                        r_b[2] <= i_in_word.bz;
                        r_c[0] <= i_in_word.cx;
                        r_c[1] <= i_in_word.cy;
                        r_c[2] <= i_in_word.cz;
                        r_state <= (i_in_word.cmd == CMD_LOAD) ? S_DONE : S_COARSE;
                    end
                end
                S_COARSE: begin
                    if (c_ovl) begin
                        r_state <= S_EDGE;
                    end else begin
                        r_cand  <= 1'b0;
                        r_state <= S_DONE;
                    end
                end
                S_EDGE: begin
                    for (int i = 0; i < 3; i++) begin
                        if (c_big) begin
                            r_u[i] <= c_t1[i][32:1];
                            r_v[i] <= c_t2[i][32:1];
                        end else begin
                            r_u[i] <= c_ue[i][31:0];
                            r_v[i] <= c_ve[i][31:0];
                        end
                    end
                    r_cnt   <= '0;
                    r_state <= S_CROSS;
                end
                S_CROSS: begin
                    // product of step cnt-1 arrives now
                    if (r_cnt != 3'd0) begin
                        if (!c_kx_odd(r_cnt)) begin
                            r_acc <= w_prod[64:0];
                        end else begin
                            r_cr[0] <= r_cr[1];
                            r_cr[1] <= r_cr[2];
                            r_cr[2] <= r_acc - w_prod[64:0];
                        end
                    end
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd6) r_state <= S_MAG;
                end
                S_MAG: begin
                    for (int i = 0; i < 3; i++) begin
                        r_mag[i] <= c_mag[i];
                        r_neg[i] <= r_cr[i][64];
                    end
                    r_m <= c_mmax;
                    if (c_mmax == 64'd0) begin
                        r_cand  <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (r_m >= 64'h8000_0000) begin
                        r_m <= r_m >> 1;
                        for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] >> 1;
                    end else if (r_m < 64'h4000_0000) begin
                        r_m <= r_m << 1;
                        for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] << 1;
                    end else begin
                        r_sum   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (r_cnt != 3'd0) r_sum <= r_sum + w_prod[63:0];
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd3) begin
                        r_kick  <= 1'b1;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (w_sq_done) begin
                        r_len   <= w_root;
                        r_cnt   <= '0;
                        r_kick  <= 1'b1;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_n[0] <= r_n[1];
                        r_n[1] <= r_n[2];
                        r_n[2] <= r_neg[c_ix] ? -32'($signed({1'b0, w_quo}))
                                              : 32'($signed({1'b0, w_quo}));
                        if (r_cnt == 3'd2) begin
                            r_cnt   <= '0;
                            r_s     <= '0;
                            r_state <= S_DOT;
                        end else begin
                            r_cnt  <= r_cnt + 3'd1;
                            r_kick <= 1'b1;
                        end
                    end
                end
                S_DOT: begin
                    if (r_cnt != 3'd0) r_s <= r_s + trunc_q30(w_prod);
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd3) r_state <= S_RAD;
                end
                S_RAD: begin
                    r_push <= c_pushw[22:0];
                    r_cnt  <= '0;
                    if (c_sabs > 38'(c_r)) begin
                        r_cand  <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (r_cnt != 3'd0) begin
                        r_newp[0] <= r_newp[1];
                        r_newp[1] <= r_newp[2];
                        r_newp[2] <= c_sat;
                        r_d[0]    <= r_d[1];
                        r_d[1]    <= r_d[2];
                        r_d[2]    <= c_dd;
                    end
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd3) begin
                        r_cnt   <= '0;
                        r_diff  <= '0;
                        r_state <= S_DIST;
                    end
                end
                S_DIST: begin
                    if (r_cnt != 3'd0) r_diff <= r_diff + w_prod[59:0];
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd3) r_state <= S_DONE;
                end
                S_DONE: begin
                    if (c_owrite) begin
                        for (int i = 0; i < 3; i++) r_pos[i] <= c_fpos[i];
                        r_ground        <= c_fground;
                        r_out.hit       <= c_commit;
                        r_out.pos_x     <= c_fpos[0];
                        r_out.pos_y     <= c_fpos[1];
                        r_out.pos_z     <= c_fpos[2];
                        r_out.on_ground <= c_fground;
                        r_out_valid     <= 1'b1;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

`ifndef SYNTH
    a_accept_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted but block still ready");

    a_word_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("output word raised outside the final step");

    a_len_normalized: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_len[31:30] != 2'b00))
        else $error("normal length below 2^30 at divide");

    a_push_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH) |-> !r_push[22])
        else $error("negative push distance");
`endif

endmodule

>>> hdl/btcp_mul.sv
// ----------------------------------------------------------------------------
// btcp_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module btcp_mul (
    input  logic                                  i_clk,
    input  logic signed [btcp_pkg::MUL_A_W-1:0]   i_a,
    input  logic signed [btcp_pkg::MUL_B_W-1:0]   i_b,
    output logic signed [btcp_pkg::MUL_P_W-1:0]   o_p
);
    import btcp_pkg::*;

    logic signed [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

>>> hdl/btcp_isqrt.sv
// ----------------------------------------------------------------------------
// btcp_isqrt
// Bit-pair serial integer square root of a 64-bit value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module btcp_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_x,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_x;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic [64:0] c_t;

    assign c_t = {1'b0, r_res} + {1'b0, r_bit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_x    <= i_x;
                r_res  <= '0;
                r_bit  <= 64'h4000_0000_0000_0000;
            end else if (r_busy) begin
                if ({1'b0, r_x} >= c_t) begin
                    r_x   <= r_x - c_t[63:0];
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[31:0];

endmodule

>>> hdl/btcp_div.sv
// ----------------------------------------------------------------------------
// btcp_div
// Restoring divider: floor(num * 2^30 / den) for num <= den, one bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module btcp_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [30:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [30:0] o_quo
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [30:0] r_quo;
    logic        c_ge;
    logic [32:0] c_diff;

    assign c_ge   = r_rem >= {1'b0, r_den};
    assign c_diff = c_ge ? r_rem - {1'b0, r_den} : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= {2'b00, i_num};
                r_den  <= i_den;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_rem <= {c_diff[31:0], 1'b0};
                r_quo <= {r_quo[29:0], c_ge};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd30) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

>>> sim/tb_box_triangle_collision_pushout.sv
// ----------------------------------------------------------------------------
// tb_box_triangle_collision_pushout
// Self-checking bench for the box/triangle push-out block: a queue-fed driver
// sends load and triangle words, and a monitor compares each output word with
// the word the in-bench Q16.16 collision model predicts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_box_triangle_collision_pushout;
    import btcp_pkg::*;

    localparam int LIMIT_CYCLES = 2000000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_word              i_in_word;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_word             o_out_word;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [31:0]           i_cfg_data;

    box_triangle_collision_pushout u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // model state
    longint    prev_frame_pos[3];
    longint    player[3];
    bit        grounded;

    t_in_word  pending_words[$];
    t_out_word expected_words[$];
    int        error_count;
    longint    cycle_count;
    bit        sender_pause;
    int        hold_off_cycles;

    function automatic longint floor_div_unit(longint v);
        return v / 65536;
    endfunction

    function automatic longint abs_l(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic bit box_overlap(longint a[3], longint b[3], longint c[3]);
        longint lo, hi, mn, mx, pmin, pmax;
        longint below[3];
        longint above[3];
        below = '{32768, 1310720, 32768};
        above = '{32768, 65536, 32768};
        for (int i = 0; i < 3; i++) begin
            mn = a[i];
            mx = a[i];
            if (b[i] < mn) mn = b[i];
            if (b[i] > mx) mx = b[i];
            if (c[i] < mn) mn = c[i];
            if (c[i] > mx) mx = c[i];
            lo = floor_div_unit(mn);
            hi = floor_div_unit(mx);
            pmin = floor_div_unit(player[i] - below[i]);
            pmax = floor_div_unit(player[i] + above[i]);
            if (pmax < lo || pmin > hi) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit plane_normal(longint a[3], longint b[3], longint c[3],
                                        output longint n[3]);
        longint u[3], v[3], cr[3];
        longint unsigned mag[3];
        longint unsigned m, len;
        longint big;
        bit neg[3];
        big = 0;
        m = 0;
        for (int i = 0; i < 3; i++) begin
            u[i] = b[i] - a[i];
            v[i] = c[i] - b[i];
            if (abs_l(u[i]) > big) big = abs_l(u[i]);
            if (abs_l(v[i]) > big) big = abs_l(v[i]);
        end
        if (big >= (64'sd1 <<< 31)) begin
            for (int i = 0; i < 3; i++) begin
                u[i] = u[i] / 2;
                v[i] = v[i] / 2;
            end
        end
        cr[0] = u[1] * v[2] - u[2] * v[1];
        cr[1] = u[2] * v[0] - u[0] * v[2];
        cr[2] = u[0] * v[1] - u[1] * v[0];
        for (int i = 0; i < 3; i++) begin
            neg[i] = cr[i] < 0;
            mag[i] = neg[i] ? 64'd0 - longint'(cr[i]) : cr[i];
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) return 1'b0;
        while (m >= (64'd1 << 31)) begin
            m = m >> 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
        end
        while (m < (64'd1 << 30)) begin
            m = m << 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
        end
        len = int_sqrt(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
        for (int i = 0; i < 3; i++) begin
            n[i] = longint'((mag[i] << 30) / len);
            if (neg[i]) n[i] = -n[i];
        end
        return 1'b1;
    endfunction

    function automatic bit push_out(longint a[3], longint b[3], longint c[3]);
        longint n[3], centre[3], newp[3], d[3];
        longint ext[3];
        longint s, racc, r, push, diff, np;
        ext = '{32768, 688128, 32768};
        if (!box_overlap(a, b, c)) return 1'b0;
        if (!plane_normal(a, b, c, n)) return 1'b0;
        centre[0] = player[0];
        centre[1] = player[1] - 622592;
        centre[2] = player[2];
        s = 0;
        racc = 0;
        for (int i = 0; i < 3; i++) begin
            s += (n[i] * (centre[i] - a[i])) / (64'sd1 <<< 30);
            racc += ext[i] * abs_l(n[i]);
        end
        r = racc >>> 30;
        if (abs_l(s) > r) return 1'b0;
        push = r - s;
        diff = 0;
        for (int i = 0; i < 3; i++) begin
            np = player[i] + (n[i] * push) / (64'sd1 <<< 30);
            if (np > 64'sd2147483647) np = 64'sd2147483647;
            if (np < -64'sd2147483648) np = -64'sd2147483648;
            newp[i] = np;
            d[i] = np - player[i];
            diff += d[i] * (d[i] + 2 * (player[i] - prev_frame_pos[i]));
        end
        if (diff > 0) return 1'b0;
        if (n[1] > 64'sd697932186) grounded = 1'b1;
        for (int i = 0; i < 3; i++) player[i] = newp[i];
        return 1'b1;
    endfunction

    function automatic t_out_word predict_word(t_in_word w);
        longint a[3], b[3], c[3];
        t_out_word o;
        a = '{longint'(w.ax), longint'(w.ay), longint'(w.az)};
        b = '{longint'(w.bx), longint'(w.by_coord), longint'(w.bz)};
        c = '{longint'(w.cx), longint'(w.cy), longint'(w.cz)};
        o.hit = 1'b0;
        if (w.cmd == CMD_LOAD) begin
            for (int i = 0; i < 3; i++) player[i] = a[i];
            grounded = 1'b0;
        end else begin
            o.hit = push_out(a, b, c);
        end
        o.pos_x = player[0][31:0];
        o.pos_y = player[1][31:0];
        o.pos_z = player[2][31:0];
        o.on_ground = grounded;
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // driver
    int send_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap <= 0;
        end else if (i_in_valid && !o_in_stall) begin
            expected_words.push_back(predict_word(i_in_word));
            if (pending_words.size() > 0 && !sender_pause && $urandom_range(0, 7) == 0) begin
                i_in_word <= pending_words.pop_front();
            end else begin
                i_in_valid <= 1'b0;
                send_gap <= $urandom_range(0, 7);
            end
        end else if (!i_in_valid) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (pending_words.size() > 0 && !sender_pause) begin
                i_in_word <= pending_words.pop_front();
                i_in_valid <= 1'b1;
            end
        end
    end

    // monitor
    int recv_gap;
    t_out_word want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b1;
            recv_gap <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word", 0, 0);
                end else begin
                    want = expected_words.pop_front();
                    if (o_out_word.hit !== want.hit)
                        report_mismatch("hit", o_out_word.hit, want.hit);
                    if (o_out_word.pos_x !== want.pos_x)
                        report_mismatch("pos_x", o_out_word.pos_x, want.pos_x);
                    if (o_out_word.pos_y !== want.pos_y)
                        report_mismatch("pos_y", o_out_word.pos_y, want.pos_y);
                    if (o_out_word.pos_z !== want.pos_z)
                        report_mismatch("pos_z", o_out_word.pos_z, want.pos_z);
                    if (o_out_word.on_ground !== want.on_ground)
                        report_mismatch("on_ground", o_out_word.on_ground, want.on_ground);
                end
                recv_gap <= $urandom_range(0, 7);
                i_out_stall <= 1'b1;
            end else if (hold_off_cycles > 0) begin
                i_out_stall <= 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_off_cycles > 0) hold_off_cycles <= hold_off_cycles - 1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("box_triangle_collision_pushout test failed");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'sh7fffffff - $urandom_range(0, 3);
            2: return 32'sh80000000 + $urandom_range(0, 3);
            default: return $signed($urandom_range(0, 40 * 65536)) - 20 * 65536;
        endcase
    endfunction

    function automatic t_in_word load_word(longint x, longint y, longint z);
        t_in_word w;
        w = '0;
        w.cmd = CMD_LOAD;
        w.ax = x[31:0];
        w.ay = y[31:0];
        w.az = z[31:0];
        w.bx = $urandom;
        w.by_coord = $urandom;
        w.bz = $urandom;
        w.cx = $urandom;
        w.cy = $urandom;
        w.cz = $urandom;
        return w;
    endfunction

    // triangle near the player so that the full plane test runs
    function automatic t_in_word near_triangle(longint px, longint py, longint pz);
        t_in_word w;
        longint bx, by, bz, j;
        j = 3 * 65536;
        bx = px + $signed($urandom_range(0, 2 * j)) - j;
        by = py - 10 * 65536 + $signed($urandom_range(0, 2 * j)) - j;
        bz = pz + $signed($urandom_range(0, 2 * j)) - j;
        w.cmd = CMD_TRI;
        w.ax = 32'(bx - 4 * 65536 + $urandom_range(0, 65535));
        w.ay = 32'(by + $signed($urandom_range(0, 2 * j)) - j);
        w.az = 32'(bz - 4 * 65536 + $urandom_range(0, 65535));
        w.bx = 32'(bx + 4 * 65536 + $urandom_range(0, 65535));
        w.by_coord = 32'(by + $signed($urandom_range(0, 2 * j)) - j);
        w.bz = 32'(bz - 4 * 65536 + $urandom_range(0, 65535));
        w.cx = 32'(bx + $signed($urandom_range(0, 2 * j)) - j);
        w.cy = 32'(by + $signed($urandom_range(0, 2 * j)) - j);
        w.cz = 32'(bz + 4 * 65536 + $urandom_range(0, 65535));
        if ($urandom_range(0, 1)) begin
            w.bx = 32'(longint'(w.ax) + $signed($urandom_range(0, 2 * j)) - j);
            w.bz = 32'(longint'(w.az) + 8 * 65536);
            w.cx = 32'(longint'(w.ax) + 8 * 65536);
            w.cz = w.az;
        end
        return w;
    endfunction

    function automatic t_in_word noise_word();
        t_in_word w;
        w.cmd = CMD_TRI;
        w.ax = rand_coord();
        w.ay = rand_coord();
        w.az = rand_coord();
        w.bx = rand_coord();
        w.by_coord = rand_coord();
        w.bz = rand_coord();
        w.cx = rand_coord();
        w.cy = rand_coord();
        w.cz = rand_coord();
        return w;
    endfunction

    // sampled at the falling edge so that driver updates have settled
    task automatic wait_drained(int tail);
        while (pending_words.size() > 0 || i_in_valid || expected_words.size() > 0)
            @(negedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        prev_frame_pos[idx] = longint'($signed(data));
    endtask

    task automatic queue_random_phase(int count);
        longint px, py, pz;
        t_in_word w;
        px = $signed($urandom_range(0, 40 * 65536)) - 20 * 65536;
        py = $signed($urandom_range(0, 40 * 65536)) - 20 * 65536;
        pz = $signed($urandom_range(0, 40 * 65536)) - 20 * 65536;
        pending_words.push_back(load_word(px, py, pz));
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(0, 9))
                0: pending_words.push_back(noise_word());
                1: begin
                    px = rand_coord();
                    py = rand_coord();
                    pz = rand_coord();
                    pending_words.push_back(load_word(px, py, pz));
                end
                default: begin
                    w = near_triangle(px, py, pz);
                    pending_words.push_back(w);
                end
            endcase
        end
    endtask

    initial begin
        t_in_word w;
        logic [31:0] ext_vals[4];
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_out_stall = 1'b1;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_LAST_X;
        i_cfg_data = '0;
        error_count = 0;
        cycle_count = 0;
        sender_pause = 1'b0;
        hold_off_cycles = 0;
        for (int i = 0; i < 3; i++) begin
            prev_frame_pos[i] = 0;
            player[i] = 0;
        end
        grounded = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: flat floor under the player, degenerate, extremes, miss
        pending_words.push_back(load_word(0, 65536, 0));
        w = '0;
        w.cmd = CMD_TRI;
        w.ax = -5 * 65536; w.ay = 0; w.az = -5 * 65536;
        w.bx = 0;          w.by_coord = 0; w.bz = 5 * 65536;
        w.cx = 5 * 65536;  w.cy = 0; w.cz = -5 * 65536;
        pending_words.push_back(w);
        w.bx = -5 * 65536; w.bz = -5 * 65536;
        w.cx = -5 * 65536; w.cz = -5 * 65536;
        pending_words.push_back(w);
        pending_words.push_back(noise_word());
        pending_words.push_back(load_word(64'sh7fffffff, 64'sh7fffffff, 64'sh7fffffff));
        w = '0;
        w.cmd = CMD_TRI;
        w.ax = 32'sh80000000; w.ay = 32'sh80000000; w.az = 32'sh80000000;
        w.bx = 32'sh7fffffff; w.by_coord = 32'sh7fffffff; w.bz = 32'sh80000000;
        w.cx = 32'sh7fffffff; w.cy = 32'sh80000000; w.cz = 32'sh7fffffff;
        pending_words.push_back(w);
        pending_words.push_back(load_word(-64'sh80000000, -64'sh80000000, -64'sh80000000));
        pending_words.push_back(w);
        pending_words.push_back(near_triangle(-64'sh7ff00000, -64'sh7ff00000, -64'sh7ff00000));
        pending_words.push_back(load_word(0, 0, 0));
        for (int k = 0; k < 10; k++) pending_words.push_back(near_triangle(0, 0, 0));
        wait_drained(250);

        // register sweeps with random phases
        ext_vals = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h0};
        for (int ph = 0; ph < 8; ph++) begin
            if (ph < 2) begin
                write_reg(CFG_LAST_X, ext_vals[ph]);
                write_reg(CFG_LAST_Y, ext_vals[ph]);
                write_reg(CFG_LAST_Z, ext_vals[ph]);
            end else begin
                write_reg(CFG_LAST_X, $urandom_range(0, 1) ? $urandom : 32'h0);
                write_reg(CFG_LAST_Y, $urandom_range(0, 1) ? $urandom : 32'h0);
                write_reg(CFG_LAST_Z, $urandom_range(0, 1) ? $urandom : 32'h0);
            end
            for (int s = 0; s < 6; s++) queue_random_phase(30);
            if (ph == 3) begin
                // long receiver hold-off while the sender keeps offering
                @(posedge i_clk);
                hold_off_cycles <= 2000;
            end
            if (ph == 5) begin
                while (pending_words.size() > 90) @(posedge i_clk);
                sender_pause = 1'b1;
                while (i_in_valid || expected_words.size() > 0) @(negedge i_clk);
                sender_pause = 1'b0;
            end
            wait_drained(250);
        end

        if (error_count == 0) begin
            $display("box_triangle_collision_pushout test passed");
        end else begin
            $display("box_triangle_collision_pushout test failed");
        end
        $finish;
    end

endmodule
